@@ rtl/core/pga_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pga_pkg
// Shared types, constants and the product term table for the PGA product.
// ----------------------------------------------------------------------------
package pga_pkg;

    localparam int MV_SIZE     = 16;
    localparam int TERM_COUNT  = 192;
    localparam int RESULT_BITS = 36;
    localparam int TERM_BITS   = 8;
    localparam int IDX_BITS    = 4;

    typedef logic [IDX_BITS-1:0]    t_idx;
    typedef logic [TERM_BITS-1:0]   t_term;
    typedef logic [RESULT_BITS-1:0] t_acc;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT,
        ST_CLEAR
    } t_state;

    // One table entry: target, left index, right index, subtract flag.
    typedef struct packed {
        t_idx dst;
        t_idx lhs;
        t_idx rhs;
        logic neg;
    } t_gp_term;

    // Request from the sequencer to the operand stores.
    typedef struct packed {
        logic we;
        t_idx waddr;
        t_idx raddr_l;
        t_idx raddr_r;
        logic clear;
    } t_store_ctl;

    function automatic t_gp_term gp_rom(input t_term n);
        t_gp_term t;
        t = '0;
        case (n)
            8'd0: t = '{4'd0,4'd0,4'd0,1'b0};
            8'd1: t = '{4'd0,4'd2,4'd2,1'b0};
            8'd2: t = '{4'd0,4'd3,4'd3,1'b0};
            8'd3: t = '{4'd0,4'd4,4'd4,1'b0};
            8'd4: t = '{4'd0,4'd8,4'd8,1'b1};
            8'd5: t = '{4'd0,4'd9,4'd9,1'b1};
            8'd6: t = '{4'd0,4'd10,4'd10,1'b1};
            8'd7: t = '{4'd0,4'd14,4'd14,1'b1};
            8'd8: t = '{4'd1,4'd0,4'd1,1'b0};
            8'd9: t = '{4'd1,4'd1,4'd0,1'b0};
            8'd10: t = '{4'd1,4'd2,4'd5,1'b1};
            8'd11: t = '{4'd1,4'd3,4'd6,1'b1};
            8'd12: t = '{4'd1,4'd4,4'd7,1'b1};
            8'd13: t = '{4'd1,4'd5,4'd2,1'b0};
            8'd14: t = '{4'd1,4'd6,4'd3,1'b0};
            8'd15: t = '{4'd1,4'd7,4'd4,1'b0};
            8'd16: t = '{4'd1,4'd8,4'd11,1'b1};
            8'd17: t = '{4'd1,4'd9,4'd12,1'b1};
            8'd18: t = '{4'd1,4'd10,4'd13,1'b1};
            8'd19: t = '{4'd1,4'd11,4'd8,1'b1};
            8'd20: t = '{4'd1,4'd12,4'd9,1'b1};
            8'd21: t = '{4'd1,4'd13,4'd10,1'b1};
            8'd22: t = '{4'd1,4'd14,4'd15,1'b0};
            8'd23: t = '{4'd1,4'd15,4'd14,1'b1};
            8'd24: t = '{4'd2,4'd0,4'd2,1'b0};
            8'd25: t = '{4'd2,4'd2,4'd0,1'b0};
            8'd26: t = '{4'd2,4'd3,4'd8,1'b1};
            8'd27: t = '{4'd2,4'd4,4'd9,1'b1};
            8'd28: t = '{4'd2,4'd8,4'd3,1'b0};
            8'd29: t = '{4'd2,4'd9,4'd4,1'b0};
            8'd30: t = '{4'd2,4'd10,4'd14,1'b1};
            8'd31: t = '{4'd2,4'd14,4'd10,1'b1};
            8'd32: t = '{4'd3,4'd0,4'd3,1'b0};
            8'd33: t = '{4'd3,4'd2,4'd8,1'b0};
            8'd34: t = '{4'd3,4'd3,4'd0,1'b0};
            8'd35: t = '{4'd3,4'd4,4'd10,1'b1};
            8'd36: t = '{4'd3,4'd8,4'd2,1'b1};
            8'd37: t = '{4'd3,4'd9,4'd14,1'b0};
            8'd38: t = '{4'd3,4'd10,4'd4,1'b0};
            8'd39: t = '{4'd3,4'd14,4'd9,1'b0};
            8'd40: t = '{4'd4,4'd0,4'd4,1'b0};
            8'd41: t = '{4'd4,4'd2,4'd9,1'b0};
            8'd42: t = '{4'd4,4'd3,4'd10,1'b0};
            8'd43: t = '{4'd4,4'd4,4'd0,1'b0};
            8'd44: t = '{4'd4,4'd8,4'd14,1'b1};
            8'd45: t = '{4'd4,4'd9,4'd2,1'b1};
            8'd46: t = '{4'd4,4'd10,4'd3,1'b1};
            8'd47: t = '{4'd4,4'd14,4'd8,1'b1};
            8'd48: t = '{4'd5,4'd0,4'd5,1'b0};
            8'd49: t = '{4'd5,4'd1,4'd2,1'b0};
            8'd50: t = '{4'd5,4'd2,4'd1,1'b1};
            8'd51: t = '{4'd5,4'd3,4'd11,1'b0};
            8'd52: t = '{4'd5,4'd4,4'd12,1'b0};
            8'd53: t = '{4'd5,4'd5,4'd0,1'b0};
            8'd54: t = '{4'd5,4'd6,4'd8,1'b1};
            8'd55: t = '{4'd5,4'd7,4'd9,1'b1};
            8'd56: t = '{4'd5,4'd8,4'd6,1'b0};
            8'd57: t = '{4'd5,4'd9,4'd7,1'b0};
            8'd58: t = '{4'd5,4'd10,4'd15,1'b1};
            8'd59: t = '{4'd5,4'd11,4'd3,1'b0};
            8'd60: t = '{4'd5,4'd12,4'd4,1'b0};
            8'd61: t = '{4'd5,4'd13,4'd14,1'b1};
            8'd62: t = '{4'd5,4'd14,4'd13,1'b0};
            8'd63: t = '{4'd5,4'd15,4'd10,1'b1};
            8'd64: t = '{4'd6,4'd0,4'd6,1'b0};
            8'd65: t = '{4'd6,4'd1,4'd3,1'b0};
            8'd66: t = '{4'd6,4'd2,4'd11,1'b1};
            8'd67: t = '{4'd6,4'd3,4'd1,1'b1};
            8'd68: t = '{4'd6,4'd4,4'd13,1'b0};
            8'd69: t = '{4'd6,4'd5,4'd8,1'b0};
            8'd70: t = '{4'd6,4'd6,4'd0,1'b0};
            8'd71: t = '{4'd6,4'd7,4'd10,1'b1};
            8'd72: t = '{4'd6,4'd8,4'd5,1'b1};
            8'd73: t = '{4'd6,4'd9,4'd15,1'b0};
            8'd74: t = '{4'd6,4'd10,4'd7,1'b0};
            8'd75: t = '{4'd6,4'd11,4'd2,1'b1};
            8'd76: t = '{4'd6,4'd12,4'd14,1'b0};
            8'd77: t = '{4'd6,4'd13,4'd4,1'b0};
            8'd78: t = '{4'd6,4'd14,4'd12,1'b1};
            8'd79: t = '{4'd6,4'd15,4'd9,1'b0};
            8'd80: t = '{4'd7,4'd0,4'd7,1'b0};
            8'd81: t = '{4'd7,4'd1,4'd4,1'b0};
            8'd82: t = '{4'd7,4'd2,4'd12,1'b1};
            8'd83: t = '{4'd7,4'd3,4'd13,1'b1};
            8'd84: t = '{4'd7,4'd4,4'd1,1'b1};
            8'd85: t = '{4'd7,4'd5,4'd9,1'b0};
            8'd86: t = '{4'd7,4'd6,4'd10,1'b0};
            8'd87: t = '{4'd7,4'd7,4'd0,1'b0};
            8'd88: t = '{4'd7,4'd8,4'd15,1'b1};
            8'd89: t = '{4'd7,4'd9,4'd5,1'b1};
            8'd90: t = '{4'd7,4'd10,4'd6,1'b1};
            8'd91: t = '{4'd7,4'd11,4'd14,1'b1};
            8'd92: t = '{4'd7,4'd12,4'd2,1'b1};
            8'd93: t = '{4'd7,4'd13,4'd3,1'b1};
            8'd94: t = '{4'd7,4'd14,4'd11,1'b0};
            8'd95: t = '{4'd7,4'd15,4'd8,1'b1};
            8'd96: t = '{4'd8,4'd0,4'd8,1'b0};
            8'd97: t = '{4'd8,4'd2,4'd3,1'b0};
            8'd98: t = '{4'd8,4'd3,4'd2,1'b1};
            8'd99: t = '{4'd8,4'd4,4'd14,1'b0};
            8'd100: t = '{4'd8,4'd8,4'd0,1'b0};
            8'd101: t = '{4'd8,4'd9,4'd10,1'b1};
            8'd102: t = '{4'd8,4'd10,4'd9,1'b0};
            8'd103: t = '{4'd8,4'd14,4'd4,1'b0};
            8'd104: t = '{4'd9,4'd0,4'd9,1'b0};
            8'd105: t = '{4'd9,4'd2,4'd4,1'b0};
            8'd106: t = '{4'd9,4'd3,4'd14,1'b1};
            8'd107: t = '{4'd9,4'd4,4'd2,1'b1};
            8'd108: t = '{4'd9,4'd8,4'd10,1'b0};
            8'd109: t = '{4'd9,4'd9,4'd0,1'b0};
            8'd110: t = '{4'd9,4'd10,4'd8,1'b1};
            8'd111: t = '{4'd9,4'd14,4'd3,1'b1};
            8'd112: t = '{4'd10,4'd0,4'd10,1'b0};
            8'd113: t = '{4'd10,4'd2,4'd14,1'b0};
            8'd114: t = '{4'd10,4'd3,4'd4,1'b0};
            8'd115: t = '{4'd10,4'd4,4'd3,1'b1};
            8'd116: t = '{4'd10,4'd8,4'd9,1'b1};
            8'd117: t = '{4'd10,4'd9,4'd8,1'b0};
            8'd118: t = '{4'd10,4'd10,4'd0,1'b0};
            8'd119: t = '{4'd10,4'd14,4'd2,1'b0};
            8'd120: t = '{4'd11,4'd0,4'd11,1'b0};
            8'd121: t = '{4'd11,4'd1,4'd8,1'b0};
            8'd122: t = '{4'd11,4'd2,4'd6,1'b1};
            8'd123: t = '{4'd11,4'd3,4'd5,1'b0};
            8'd124: t = '{4'd11,4'd4,4'd15,1'b1};
            8'd125: t = '{4'd11,4'd5,4'd3,1'b0};
            8'd126: t = '{4'd11,4'd6,4'd2,1'b1};
            8'd127: t = '{4'd11,4'd7,4'd14,1'b0};
            8'd128: t = '{4'd11,4'd8,4'd1,1'b0};
            8'd129: t = '{4'd11,4'd9,4'd13,1'b1};
            8'd130: t = '{4'd11,4'd10,4'd12,1'b0};
            8'd131: t = '{4'd11,4'd11,4'd0,1'b0};
            8'd132: t = '{4'd11,4'd12,4'd10,1'b1};
            8'd133: t = '{4'd11,4'd13,4'd9,1'b0};
            8'd134: t = '{4'd11,4'd14,4'd7,1'b1};
            8'd135: t = '{4'd11,4'd15,4'd4,1'b0};
            8'd136: t = '{4'd12,4'd0,4'd12,1'b0};
            8'd137: t = '{4'd12,4'd1,4'd9,1'b0};
            8'd138: t = '{4'd12,4'd2,4'd7,1'b1};
            8'd139: t = '{4'd12,4'd3,4'd15,1'b0};
            8'd140: t = '{4'd12,4'd4,4'd5,1'b0};
            8'd141: t = '{4'd12,4'd5,4'd4,1'b0};
            8'd142: t = '{4'd12,4'd6,4'd14,1'b1};
            8'd143: t = '{4'd12,4'd7,4'd2,1'b1};
            8'd144: t = '{4'd12,4'd8,4'd13,1'b0};
            8'd145: t = '{4'd12,4'd9,4'd1,1'b0};
            8'd146: t = '{4'd12,4'd10,4'd11,1'b1};
            8'd147: t = '{4'd12,4'd11,4'd10,1'b0};
            8'd148: t = '{4'd12,4'd12,4'd0,1'b0};
            8'd149: t = '{4'd12,4'd13,4'd8,1'b1};
            8'd150: t = '{4'd12,4'd14,4'd6,1'b0};
            8'd151: t = '{4'd12,4'd15,4'd3,1'b1};
            8'd152: t = '{4'd13,4'd0,4'd13,1'b0};
            8'd153: t = '{4'd13,4'd1,4'd10,1'b0};
            8'd154: t = '{4'd13,4'd2,4'd15,1'b1};
            8'd155: t = '{4'd13,4'd3,4'd7,1'b1};
            8'd156: t = '{4'd13,4'd4,4'd6,1'b0};
            8'd157: t = '{4'd13,4'd5,4'd14,1'b0};
            8'd158: t = '{4'd13,4'd6,4'd4,1'b0};
            8'd159: t = '{4'd13,4'd7,4'd3,1'b1};
            8'd160: t = '{4'd13,4'd8,4'd12,1'b1};
            8'd161: t = '{4'd13,4'd9,4'd11,1'b0};
            8'd162: t = '{4'd13,4'd10,4'd1,1'b0};
            8'd163: t = '{4'd13,4'd11,4'd9,1'b1};
            8'd164: t = '{4'd13,4'd12,4'd8,1'b0};
            8'd165: t = '{4'd13,4'd13,4'd0,1'b0};
            8'd166: t = '{4'd13,4'd14,4'd5,1'b1};
            8'd167: t = '{4'd13,4'd15,4'd2,1'b0};
            8'd168: t = '{4'd14,4'd0,4'd14,1'b0};
            8'd169: t = '{4'd14,4'd2,4'd10,1'b0};
            8'd170: t = '{4'd14,4'd3,4'd9,1'b1};
            8'd171: t = '{4'd14,4'd4,4'd8,1'b0};
            8'd172: t = '{4'd14,4'd8,4'd4,1'b0};
            8'd173: t = '{4'd14,4'd9,4'd3,1'b1};
            8'd174: t = '{4'd14,4'd10,4'd2,1'b0};
            8'd175: t = '{4'd14,4'd14,4'd0,1'b0};
            8'd176: t = '{4'd15,4'd0,4'd15,1'b0};
            8'd177: t = '{4'd15,4'd1,4'd14,1'b0};
            8'd178: t = '{4'd15,4'd2,4'd13,1'b1};
            8'd179: t = '{4'd15,4'd3,4'd12,1'b0};
            8'd180: t = '{4'd15,4'd4,4'd11,1'b1};
            8'd181: t = '{4'd15,4'd5,4'd10,1'b0};
            8'd182: t = '{4'd15,4'd6,4'd9,1'b1};
            8'd183: t = '{4'd15,4'd7,4'd8,1'b0};
            8'd184: t = '{4'd15,4'd8,4'd7,1'b0};
            8'd185: t = '{4'd15,4'd9,4'd6,1'b1};
            8'd186: t = '{4'd15,4'd10,4'd5,1'b0};
            8'd187: t = '{4'd15,4'd11,4'd4,1'b0};
            8'd188: t = '{4'd15,4'd12,4'd3,1'b1};
            8'd189: t = '{4'd15,4'd13,4'd2,1'b0};
            8'd190: t = '{4'd15,4'd14,4'd1,1'b1};
            8'd191: t = '{4'd15,4'd15,4'd0,1'b0};
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

@@ rtl/core/pga_operand_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pga_operand_store
// Paired left and right operand memories with registered reads.
// ----------------------------------------------------------------------------
module pga_operand_store #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                          i_clk,
    input  pga_pkg::t_store_ctl           i_ctl,
    input  logic [COMPONENT_BITS-1:0]     i_wdata_l,
    input  logic [COMPONENT_BITS-1:0]     i_wdata_r,
    output logic [COMPONENT_BITS-1:0]     o_rdata_l,
    output logic [COMPONENT_BITS-1:0]     o_rdata_r
);
    import pga_pkg::*;

    logic [COMPONENT_BITS-1:0] r_mem_l [MV_SIZE];
    logic [COMPONENT_BITS-1:0] r_mem_r [MV_SIZE];

    // Write port: a load writes the pair, a clear step writes zeros.
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem_l[i_ctl.waddr] <= i_ctl.clear ? '0 : i_wdata_l;
            r_mem_r[i_ctl.waddr] <= i_ctl.clear ? '0 : i_wdata_r;
        end
    end

    // Registered read ports.
    always_ff @(posedge i_clk) begin
        o_rdata_l <= r_mem_l[i_ctl.raddr_l];
        o_rdata_r <= r_mem_r[i_ctl.raddr_r];
    end

endmodule

@@ rtl/core/pga_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pga_mac
// Multiplier stage and accumulator memory with read-modify-write forwarding.
// ----------------------------------------------------------------------------
module pga_mac #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_op_valid,
    input  pga_pkg::t_idx                     i_op_dst,
    input  logic                              i_op_neg,
    input  logic signed [COMPONENT_BITS-1:0]  i_op_a,
    input  logic signed [COMPONENT_BITS-1:0]  i_op_b,
    input  logic                              i_clr,
    input  pga_pkg::t_idx                     i_rd_addr,
    output pga_pkg::t_acc                     o_rd_data
);
    import pga_pkg::*;

    localparam int PROD_BITS = 2 * COMPONENT_BITS;

    t_acc r_acc [MV_SIZE];
    logic [MV_SIZE-1:0] r_live;

    // Stage 1: multiply, with the accumulator entry read in parallel.
    logic signed [PROD_BITS-1:0] r_prod;
    logic r_p_valid;
    logic r_p_neg;
    t_idx r_p_dst;
    t_acc r_p_old;

    // Stage 2: the write back of the previous step, forwarded when needed.
    logic r_w_valid;
    t_idx r_w_dst;
    t_acc r_w_data;

    t_acc n_sum;
    t_acc w_old;
    t_acc w_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_w_valid <= 1'b0;
        end else begin
            r_p_valid <= i_op_valid;
            r_w_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= i_op_a * i_op_b;
        r_p_neg  <= i_op_neg;
        r_p_dst  <= i_op_dst;
        r_p_old  <= r_live[i_op_dst] ? r_acc[i_op_dst] : '0;
        r_w_dst  <= r_p_dst;
        r_w_data <= n_sum;
        o_rd_data <= r_acc[i_rd_addr];
    end

    // Forward the entry written this cycle if stage 1 read a stale copy.
    always_comb begin
        w_prod = t_acc'(r_prod);
        w_old  = (r_w_valid && r_w_dst == r_p_dst) ? r_w_data : r_p_old;
        n_sum  = r_p_neg ? (w_old - w_prod) : (w_old + w_prod);
    end

    // Accumulator write back; live bits make a cleared entry read as zero.
    always_ff @(posedge i_clk) begin
        if (r_p_valid) begin
            r_acc[r_p_dst] <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_live <= '0;
        end else if (r_p_valid) begin
            r_live[r_p_dst] <= 1'b1;
        end
    end

endmodule

@@ rtl/core/pga_geometric_product_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pga_geometric_product_unit
// Geometric product of two 3D PGA multivectors loaded one component a word.
// ----------------------------------------------------------------------------
// Every accepted load word is written to the operand stores; a last word also starts 192
// table steps through the shared multiplier, a drain, 16 result words and a
// store clear. Output stalls lengthen a run.
// The table walk takes one term a cycle.
// Reset (synchronous, active low) empties the operand stores by a clearing
// pass, during which no word is accepted.
module pga_geometric_product_unit #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [3:0]                        i_component_index,
    input  logic signed [COMPONENT_BITS-1:0]  i_a_component,
    input  logic signed [COMPONENT_BITS-1:0]  i_b_component,
    input  logic                              i_last_component,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [3:0]                        o_result_index,
    output logic signed [35:0]                o_product_component,
    output logic                              o_last_result
);
    import pga_pkg::*;

    t_state r_state, n_state;
    t_term  r_term, n_term;
    t_idx   r_cnt, n_cnt;
    logic   r_ovalid, n_ovalid;
    logic   r_issue;
    t_gp_term w_t;
    t_store_ctl w_ctl;
    logic w_accept;
    logic w_clr;
    logic [COMPONENT_BITS-1:0] w_rl, w_rr;
    t_acc w_acc;
    t_idx r_oidx;
    logic r_rd_pending;

    assign w_t      = gp_rom(r_term);
    assign w_accept = i_valid && !o_stall;

    pga_operand_store #(.COMPONENT_BITS(COMPONENT_BITS)) u_store (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_wdata_l (i_a_component),
        .i_wdata_r (i_b_component),
        .o_rdata_l (w_rl),
        .o_rdata_r (w_rr)
    );

    pga_mac #(.COMPONENT_BITS(COMPONENT_BITS)) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (r_issue),
        .i_op_dst   (r_oidx),
        .i_op_neg   (r_rd_pending),
        .i_op_a     (w_rl),
        .i_op_b     (w_rr),
        .i_clr      (w_clr),
        .i_rd_addr  (r_cnt),
        .o_rd_data  (w_acc)
    );

    // Term fields delayed to line up with the registered operand reads.
    always_ff @(posedge i_clk) begin
        r_oidx       <= w_t.dst;
        r_rd_pending <= w_t.neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_term   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_issue  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_term   <= n_term;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            r_issue  <= (r_state == ST_MAC);
        end
    end

    // Output index and last flag register, loaded from the result counter.
    always_ff @(posedge i_clk) begin
        if (n_ovalid && (!r_ovalid || !i_stall)) begin
            o_result_index      <= r_cnt;
            o_last_result       <= (r_cnt == t_idx'(MV_SIZE - 1));
        end
    end

    // Sequencer: load, table walk, drain, emit, clear.
    always_comb begin
        n_state  = r_state;
        n_term   = r_term;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && i_stall;
        o_stall  = 1'b1;
        w_clr    = 1'b0;
        w_ctl    = '{we: 1'b0, waddr: i_component_index, raddr_l: w_t.lhs,
                     raddr_r: w_t.rhs, clear: 1'b0};
        case (r_state)
            ST_LOAD: begin
                o_stall   = 1'b0;
                w_ctl.we  = i_valid;
                if (w_accept && i_last_component) begin
                    n_state = ST_MAC;
                    n_term  = '0;
                    w_clr   = 1'b1;
                end
            end
            ST_MAC: begin
                n_term = r_term + 1'b1;
                if (r_term == t_term'(TERM_COUNT - 1)) begin
                    n_state = ST_DRAIN;
                    n_cnt   = '0;
                    n_term  = '0;
                end
            end
            ST_DRAIN: begin
                // Let the last product reach the accumulators, then read entry 0.
                n_term = r_term + 1'b1;
                if (r_term == t_term'(3)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    if (r_cnt == t_idx'(MV_SIZE - 1)) begin
                        n_state = ST_CLEAR;
                    end
                    n_cnt = (r_ovalid || r_term != '0) ? r_cnt + 1'b1 : r_cnt;
                    n_term = '0;
                end
            end
            ST_CLEAR: begin
                w_ctl.we    = 1'b1;
                w_ctl.clear = 1'b1;
                w_ctl.waddr = r_cnt;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == t_idx'(MV_SIZE - 1)) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Result data tracks the read port while the word is not held.
    logic r_hold;
    t_acc r_data;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
        end else begin
            r_hold <= r_ovalid && i_stall;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!r_hold) begin
            r_data <= w_acc;
        end
    end
    assign o_product_component = r_hold ? r_data : w_acc;
    assign o_valid = r_ovalid;

    // Assertions.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> o_stall)
        else $error("word accepted while busy");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result_index)))
        else $error("result word lost under stall");
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_result) |=> (r_state == ST_CLEAR || !o_valid))
        else $error("last word not at end of run");

endmodule
